// ===== design/seg_ev_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment eviction selector package
// Shared widths, codes, register indexes, record types and sequencer states.
// ----------------------------------------------------------------------------
package seg_ev_pkg;

   localparam int MAX_SEGMENTS_DEFAULT = 1024;

   localparam int SEG_INDEX_W = 10;
   localparam int TIME_W      = 32;
   localparam int TTL_W       = 31;
   localparam int LIVE_W      = 32;
   localparam int RANDOM_W    = 16;
   localparam int MODE_W      = 2;
   localparam int COUNT_W     = 11;
   localparam int SHORT_W     = 16;
   localparam int FLAGS_W     = 3;
   localparam int KEY_W       = 33;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FIFO   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EXPIRY = 2'd2;
   localparam logic [MODE_W-1:0] MODE_LIVE   = 2'd3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVICT = 1'b1;

   localparam logic STATUS_FOUND = 1'b0;
   localparam logic STATUS_NONE  = 1'b1;

   // Writer idle, evictable mark set, successor present.
   localparam logic [FLAGS_W-1:0] FLAGS_QUALIFY = 3'b110;

   localparam logic [CSR_INDEX_W-1:0] REG_POLICY_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SEGMENT_COUNT   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MATURE_TIME     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_EXPIRE_MARGIN   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RERANK_INTERVAL = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_RERANK_SLACK    = 3'd5;

   localparam logic [MODE_W-1:0]  RESET_POLICY_MODE     = MODE_FIFO;
   localparam logic [COUNT_W-1:0] RESET_SEGMENT_COUNT   = 11'd1024;
   localparam logic [TIME_W-1:0]  RESET_MATURE_TIME     = 32'd0;
   localparam logic [SHORT_W-1:0] RESET_EXPIRE_MARGIN   = 16'd20;
   localparam logic [SHORT_W-1:0] RESET_RERANK_INTERVAL = 16'd1;
   localparam logic [COUNT_W-1:0] RESET_RERANK_SLACK    = 11'd8;

   typedef struct packed {
      logic [FLAGS_W-1:0] flags;
      logic [TIME_W-1:0]  created;
      logic [TIME_W-1:0]  merged;
      logic [TTL_W-1:0]   ttl;
      logic [LIVE_W-1:0]  live;
   } meta_type;

   typedef struct packed {
      logic             qualified;
      logic [KEY_W-1:0] key;
   } eval_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_CHECK,
      ST_RANK_RD,
      ST_RANK_ID,
      ST_PROBE_RD,
      ST_PROBE_W1,
      ST_PROBE_W2,
      ST_PROBE_DEC,
      ST_FILL_RD,
      ST_FILL_W1,
      ST_FILL_W2,
      ST_FILL_WR,
      ST_MERGE_INIT,
      ST_SEG_SETUP,
      ST_MRG_RD,
      ST_MRG_WR,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      RET_SEARCH,
      RET_REDO,
      RET_FAIL
   } ret_type;

endpackage

// ===== design/segment_eviction_selector_top.sv =====
// ----------------------------------------------------------------------------
// Segment eviction selector
// Holds per-segment metadata and picks a segment to evict by random probe or
// from a ranked list kept by merge sort.
// ----------------------------------------------------------------------------
// After reset the block sweeps its metadata and rank tables and takes no
// transaction meanwhile. A metadata write is taken while idle. An eviction
// request is handled one at a time through one shared qualification unit and
// a sequencer: a random probe reduces the random start modulo the segment
// count and tries segments in turn; a ranked lookup tries list entries in
// turn from the cursor; a rebuild of the ranked list over n segments scores
// the table, runs ceil(log2 n) merge passes and publishes the list.
// ----------------------------------------------------------------------------
module segment_eviction_selector_top #(
   parameter int MAX_SEGMENTS = seg_ev_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic [seg_ev_pkg::TIME_W-1:0]          req_now_sec,
   input  logic [seg_ev_pkg::SEG_INDEX_W-1:0]     req_seg_index,
   input  logic                                   req_writer_busy,
   input  logic                                   req_marked_evictable,
   input  logic                                   req_has_successor,
   input  logic [seg_ev_pkg::TIME_W-1:0]          req_created_sec,
   input  logic [seg_ev_pkg::TIME_W-1:0]          req_merged_sec,
   input  logic [seg_ev_pkg::TTL_W-1:0]           req_ttl_sec,
   input  logic [seg_ev_pkg::LIVE_W-1:0]          req_live_byte_count,
   input  logic [seg_ev_pkg::RANDOM_W-1:0]        req_random_start,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [seg_ev_pkg::SEG_INDEX_W-1:0]     rsp_chosen_segment,
   output logic                                   rsp_result_status,
   input  logic                                   csr_write,
   input  logic [seg_ev_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [seg_ev_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import seg_ev_pkg::*;

   localparam int IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int SUM_W  = CNT_W + 2;
   localparam int ELEM_W = 1 + KEY_W + IDX_W;
   localparam int BIT_W  = $clog2(RANDOM_W);

   // Configuration registers.
   logic [MODE_W-1:0]  mode_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [TIME_W-1:0]  mature_ff;
   logic [SHORT_W-1:0] margin_ff;
   logic [SHORT_W-1:0] interval_ff;
   logic [COUNT_W-1:0] slack_ff;

   // Sequencer and request state.
   state_type         state_ff, state_in;
   ret_type           ret_ff, ret_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [RANDOM_W-1:0] rand_ff, rand_in;
   logic [TIME_W:0]   nm_ff, nm_in;
   logic [SUM_W-1:0]  ctr_ff, ctr_in;
   logic [CNT_W-1:0]  cursor_ff, cursor_in;
   logic [TIME_W-1:0] last_ff, last_in;
   logic              done_ff, done_in;
   logic              redone_ff, redone_in;
   logic [IDX_W-1:0]  id_ff, id_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [SUM_W-1:0]  w_ff, w_in;
   logic [SUM_W-1:0]  lo_ff, lo_in;
   logic [SUM_W-1:0]  mid_ff, mid_in;
   logic [SUM_W-1:0]  hi_ff, hi_in;
   logic [SUM_W-1:0]  p_ff, p_in;
   logic [SUM_W-1:0]  q_ff, q_in;
   logic [SUM_W-1:0]  k_ff, k_in;
   logic              sel_ff, sel_in;
   logic [IDX_W-1:0]  res_id_ff, res_id_in;
   logic              res_none_ff, res_none_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SEG_INDEX_W-1:0] rsp_id_ff, rsp_id_in;
   logic              rsp_status_ff, rsp_status_in;

   // Memories.
   meta_type          meta_mem [MAX_SEGMENTS];
   meta_type          meta_rd_ff;
   logic              meta_we;
   logic [IDX_W-1:0]  meta_waddr, meta_raddr;
   meta_type          meta_wdata;

   logic [ELEM_W-1:0] sort_a_mem [MAX_SEGMENTS];
   logic [ELEM_W-1:0] sort_b_mem [MAX_SEGMENTS];
   logic [ELEM_W-1:0] a_rd0_ff, a_rd1_ff, b_rd0_ff, b_rd1_ff;
   logic              sort_a_we, sort_b_we;
   logic [IDX_W-1:0]  sort_waddr, sort_raddr0, sort_raddr1;
   logic [ELEM_W-1:0] sort_wdata;

   logic [IDX_W-1:0]  rank_mem [MAX_SEGMENTS];
   logic [IDX_W-1:0]  rank_rd_ff;
   logic              rank_we;
   logic [IDX_W-1:0]  rank_waddr, rank_raddr, rank_wdata;

   // Shared conditions.
   eval_type          eval_out;
   logic [31:0]       count_ext, n_ext, seg_ext, id_ext;
   logic [SUM_W-1:0]  n_s, pos, pos_next, ctr_next, lo_w, lo_2w, w_2;
   logic [CNT_W:0]    rem_shift, n_rem;
   logic [TIME_W:0]   since_rank;
   logic [SUM_W-1:0]  n_minus_cursor;
   logic              accept, seg_in_range, rebuild, redo_cond, take_p, seg_end;
   logic              ctr_last, rsp_free, probe_random;
   logic [ELEM_W-1:0] src_rd0, src_rd1;
   logic [IDX_W-1:0]  id_next;

   seg_ev_eval u_eval (
      .clock      (clock),
      .meta       (meta_rd_ff),
      .now        (now_ff),
      .now_margin (nm_ff),
      .mature     (mature_ff),
      .mode       (mode_ff),
      .result     (eval_out)
   );

   always_comb begin
      count_ext = 32'(count_ff);
      if (count_ext == 32'd0) begin
         n_ext = 32'd1;
      end else if (count_ext > 32'(MAX_SEGMENTS)) begin
         n_ext = 32'(MAX_SEGMENTS);
      end else begin
         n_ext = count_ext;
      end
   end

   assign n_s            = SUM_W'(n_ext);
   assign seg_ext        = 32'(req_seg_index);
   assign seg_in_range   = seg_ext < 32'(MAX_SEGMENTS);
   assign accept         = req_valid && !req_stall;
   assign pos            = SUM_W'(cursor_ff) + ctr_ff;
   assign pos_next       = pos + SUM_W'(1);
   assign ctr_next       = ctr_ff + SUM_W'(1);
   assign ctr_last       = ctr_next >= n_s;
   assign since_rank     = {1'b0, now_ff} - {1'b0, last_ff};
   assign n_minus_cursor = n_s - SUM_W'(cursor_ff);
   assign rebuild        = !done_ff || (SUM_W'(cursor_ff) >= n_s) ||
                           ($signed(since_rank) > $signed({17'b0, interval_ff})) ||
                           (n_minus_cursor < SUM_W'(slack_ff));
   assign redo_cond      = !redone_ff && ((SUM_W'(cursor_ff) + ctr_next) >= n_s);
   assign rem_shift      = {rem_ff, rand_ff[bit_ff]};
   assign n_rem          = (CNT_W + 1)'(n_s);
   assign src_rd0        = sel_ff ? b_rd0_ff : a_rd0_ff;
   assign src_rd1        = sel_ff ? b_rd1_ff : a_rd1_ff;
   assign take_p         = (p_ff < mid_ff) && ((q_ff >= hi_ff) || (src_rd0 <= src_rd1));
   assign seg_end        = (k_ff + SUM_W'(1)) >= hi_ff;
   assign lo_w           = lo_ff + w_ff;
   assign lo_2w          = lo_ff + w_2;
   assign w_2            = w_ff << 1;
   assign probe_random   = (mode_ff == MODE_RANDOM);
   assign id_next        = ((SUM_W'(id_ff) + SUM_W'(1)) >= n_s) ? '0 : id_ff + IDX_W'(1);
   assign rsp_free       = !rsp_valid_ff || !rsp_stall;
   assign id_ext         = 32'(res_id_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (ctr_ff == SUM_W'(MAX_SEGMENTS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && (req_opcode == OP_EVICT)) state_in = ST_START;
         end
         ST_START: begin
            state_in = probe_random ? ST_DIV : ST_CHECK;
         end
         ST_DIV: begin
            if (bit_ff == '0) state_in = ST_PROBE_RD;
         end
         ST_CHECK: begin
            state_in = rebuild ? ST_FILL_RD : ST_RANK_RD;
         end
         ST_RANK_RD:  state_in = ST_RANK_ID;
         ST_RANK_ID:  state_in = ST_PROBE_RD;
         ST_PROBE_RD: state_in = ST_PROBE_W1;
         ST_PROBE_W1: state_in = ST_PROBE_W2;
         ST_PROBE_W2: state_in = ST_PROBE_DEC;
         ST_PROBE_DEC: begin
            priority if (eval_out.qualified) begin
               state_in = ST_RESP;
            end else if (probe_random) begin
               state_in = ctr_last ? ST_RESP : ST_PROBE_RD;
            end else if (redo_cond || ctr_last) begin
               state_in = ST_FILL_RD;
            end else begin
               state_in = ST_RANK_RD;
            end
         end
         ST_FILL_RD: state_in = ST_FILL_W1;
         ST_FILL_W1: state_in = ST_FILL_W2;
         ST_FILL_W2: state_in = ST_FILL_WR;
         ST_FILL_WR: begin
            state_in = ctr_last ? ST_MERGE_INIT : ST_FILL_RD;
         end
         ST_MERGE_INIT: begin
            state_in = (n_s <= SUM_W'(1)) ? ST_COPY_RD : ST_SEG_SETUP;
         end
         ST_SEG_SETUP: begin
            if (lo_ff >= n_s) begin
               state_in = (w_2 >= n_s) ? ST_COPY_RD : ST_SEG_SETUP;
            end else begin
               state_in = ST_MRG_RD;
            end
         end
         ST_MRG_RD: state_in = ST_MRG_WR;
         ST_MRG_WR: begin
            state_in = seg_end ? ST_SEG_SETUP : ST_MRG_RD;
         end
         ST_COPY_RD: state_in = ST_COPY_WR;
         ST_COPY_WR: begin
            if (ctr_last) begin
               state_in = (ret_ff == RET_FAIL) ? ST_RESP : ST_RANK_RD;
            end else begin
               state_in = ST_COPY_RD;
            end
         end
         ST_RESP: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      ret_in        = ret_ff;
      now_in        = now_ff;
      rand_in       = rand_ff;
      nm_in         = nm_ff;
      ctr_in        = ctr_ff;
      cursor_in     = cursor_ff;
      last_in       = last_ff;
      done_in       = done_ff;
      redone_in     = redone_ff;
      id_in         = id_ff;
      rem_in        = rem_ff;
      bit_in        = bit_ff;
      w_in          = w_ff;
      lo_in         = lo_ff;
      mid_in        = mid_ff;
      hi_in         = hi_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      k_in          = k_ff;
      sel_in        = sel_ff;
      res_id_in     = res_id_ff;
      res_none_in   = res_none_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      meta_we       = 1'b0;
      meta_waddr    = seg_ext[IDX_W-1:0];
      meta_raddr    = id_ff;
      meta_wdata    = '0;
      sort_a_we     = 1'b0;
      sort_b_we     = 1'b0;
      sort_waddr    = k_ff[IDX_W-1:0];
      sort_raddr0   = p_ff[IDX_W-1:0];
      sort_raddr1   = q_ff[IDX_W-1:0];
      sort_wdata    = take_p ? src_rd0 : src_rd1;
      rank_we       = 1'b0;
      rank_waddr    = ctr_ff[IDX_W-1:0];
      rank_raddr    = pos[IDX_W-1:0];
      rank_wdata    = src_rd0[IDX_W-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = ctr_ff[IDX_W-1:0];
            rank_we    = 1'b1;
            rank_wdata = ctr_ff[IDX_W-1:0];
            ctr_in     = (ctr_ff == SUM_W'(MAX_SEGMENTS - 1)) ? '0 : ctr_next;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_WRITE) begin
                  meta_we            = seg_in_range;
                  meta_wdata.flags   = {req_has_successor, req_marked_evictable,
                                        req_writer_busy};
                  meta_wdata.created = req_created_sec;
                  meta_wdata.merged  = req_merged_sec;
                  meta_wdata.ttl     = req_ttl_sec;
                  meta_wdata.live    = req_live_byte_count;
               end else begin
                  now_in  = req_now_sec;
                  rand_in = req_random_start;
               end
            end
         end
         ST_START: begin
            nm_in     = {1'b0, now_ff} + (TIME_W + 1)'(margin_ff);
            rem_in    = '0;
            bit_in    = BIT_W'(RANDOM_W - 1);
            ctr_in    = '0;
            redone_in = 1'b0;
         end
         ST_DIV: begin
            rem_in = (rem_shift >= n_rem) ? CNT_W'(rem_shift - n_rem) : CNT_W'(rem_shift);
            bit_in = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               id_in = (rem_shift >= n_rem) ? IDX_W'(rem_shift - n_rem) : IDX_W'(rem_shift);
            end
         end
         ST_CHECK: begin
            ret_in    = RET_SEARCH;
            ctr_in    = '0;
            redone_in = 1'b0;
         end
         ST_RANK_RD: begin
            rank_raddr = pos[IDX_W-1:0];
         end
         ST_RANK_ID: begin
            id_in = rank_rd_ff;
         end
         ST_PROBE_RD: begin
            meta_raddr = id_ff;
         end
         ST_PROBE_W1, ST_PROBE_W2, ST_FILL_W1, ST_FILL_W2, ST_MRG_RD, ST_RESP: begin
         end
         ST_PROBE_DEC: begin
            priority if (eval_out.qualified) begin
               res_id_in   = id_ff;
               res_none_in = 1'b0;
               if (!probe_random) begin
                  cursor_in = (pos_next >= n_s) ? '0 : CNT_W'(pos_next);
               end
            end else if (probe_random) begin
               if (ctr_last) begin
                  res_id_in   = '0;
                  res_none_in = 1'b1;
               end else begin
                  ctr_in = ctr_next;
                  id_in  = id_next;
               end
            end else if (redo_cond) begin
               ret_in = RET_REDO;
               ctr_in = '0;
            end else if (ctr_last) begin
               ret_in = RET_FAIL;
               ctr_in = '0;
            end else begin
               ctr_in = ctr_next;
            end
         end
         ST_FILL_RD: begin
            meta_raddr = ctr_ff[IDX_W-1:0];
         end
         ST_FILL_WR: begin
            sort_a_we  = 1'b1;
            sort_waddr = ctr_ff[IDX_W-1:0];
            sort_wdata = {!eval_out.qualified,
                          eval_out.qualified ? eval_out.key : {KEY_W{1'b0}},
                          ctr_ff[IDX_W-1:0]};
            ctr_in     = ctr_next;
         end
         ST_MERGE_INIT: begin
            w_in   = SUM_W'(1);
            lo_in  = '0;
            sel_in = 1'b0;
            ctr_in = '0;
         end
         ST_SEG_SETUP: begin
            if (lo_ff >= n_s) begin
               w_in   = w_2;
               sel_in = !sel_ff;
               lo_in  = '0;
            end else begin
               mid_in = (lo_w < n_s) ? lo_w : n_s;
               hi_in  = (lo_2w < n_s) ? lo_2w : n_s;
               p_in   = lo_ff;
               q_in   = (lo_w < n_s) ? lo_w : n_s;
               k_in   = lo_ff;
            end
         end
         ST_MRG_WR: begin
            sort_a_we  = sel_ff;
            sort_b_we  = !sel_ff;
            sort_waddr = k_ff[IDX_W-1:0];
            sort_wdata = take_p ? src_rd0 : src_rd1;
            k_in       = k_ff + SUM_W'(1);
            if (take_p) begin
               p_in = p_ff + SUM_W'(1);
            end else begin
               q_in = q_ff + SUM_W'(1);
            end
            if (seg_end) lo_in = lo_2w;
         end
         ST_COPY_RD: begin
            sort_raddr0 = ctr_ff[IDX_W-1:0];
         end
         ST_COPY_WR: begin
            rank_we    = 1'b1;
            rank_waddr = ctr_ff[IDX_W-1:0];
            rank_wdata = src_rd0[IDX_W-1:0];
            ctr_in     = ctr_next;
            if (ctr_last) begin
               ctr_in    = '0;
               cursor_in = '0;
               last_in   = now_ff;
               done_in   = 1'b1;
               unique case (ret_ff)
                  RET_SEARCH: redone_in = 1'b0;
                  RET_REDO:   redone_in = 1'b1;
                  RET_FAIL: begin
                     res_id_in   = '0;
                     res_none_in = 1'b1;
                  end
                  default: redone_in = redone_ff;
               endcase
            end
         end
         default: begin
         end
      endcase

      if ((state_ff == ST_RESP) && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_id_in     = res_none_ff ? '0 : id_ext[SEG_INDEX_W-1:0];
         rsp_status_in = res_none_ff ? STATUS_NONE : STATUS_FOUND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= RESET_POLICY_MODE;
         count_ff    <= RESET_SEGMENT_COUNT;
         mature_ff   <= RESET_MATURE_TIME;
         margin_ff   <= RESET_EXPIRE_MARGIN;
         interval_ff <= RESET_RERANK_INTERVAL;
         slack_ff    <= RESET_RERANK_SLACK;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_POLICY_MODE:     mode_ff     <= csr_wdata[MODE_W-1:0];
            REG_SEGMENT_COUNT:   count_ff    <= csr_wdata[COUNT_W-1:0];
            REG_MATURE_TIME:     mature_ff   <= csr_wdata[TIME_W-1:0];
            REG_EXPIRE_MARGIN:   margin_ff   <= csr_wdata[SHORT_W-1:0];
            REG_RERANK_INTERVAL: interval_ff <= csr_wdata[SHORT_W-1:0];
            REG_RERANK_SLACK:    slack_ff    <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ctr_ff       <= '0;
         cursor_ff    <= '0;
         last_ff      <= '0;
         done_ff      <= 1'b0;
         redone_ff    <= 1'b0;
         ret_ff       <= RET_SEARCH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         cursor_ff    <= cursor_in;
         last_ff      <= last_in;
         done_ff      <= done_in;
         redone_ff    <= redone_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      rand_ff       <= rand_in;
      nm_ff         <= nm_in;
      id_ff         <= id_in;
      rem_ff        <= rem_in;
      bit_ff        <= bit_in;
      w_ff          <= w_in;
      lo_ff         <= lo_in;
      mid_ff        <= mid_in;
      hi_ff         <= hi_in;
      p_ff          <= p_in;
      q_ff          <= q_in;
      k_ff          <= k_in;
      sel_ff        <= sel_in;
      res_id_ff     <= res_id_in;
      res_none_ff   <= res_none_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
      meta_rd_ff <= meta_mem[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (sort_a_we) sort_a_mem[sort_waddr] <= sort_wdata;
      a_rd0_ff <= sort_a_mem[sort_raddr0];
      a_rd1_ff <= sort_a_mem[sort_raddr1];
   end

   always_ff @(posedge clock) begin
      if (sort_b_we) sort_b_mem[sort_waddr] <= sort_wdata;
      b_rd0_ff <= sort_b_mem[sort_raddr0];
      b_rd1_ff <= sort_b_mem[sort_raddr1];
   end

   always_ff @(posedge clock) begin
      if (rank_we) rank_mem[rank_waddr] <= rank_wdata;
      rank_rd_ff <= rank_mem[rank_raddr];
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_chosen_segment = rsp_id_ff;
   assign rsp_result_status  = rsp_status_ff;

endmodule

// ===== design/seg_ev_eval.sv =====
// ----------------------------------------------------------------------------
// Segment qualification unit
// Two-stage pipeline that judges whether one segment may be evicted and forms
// its ranking key for the current policy.
// ----------------------------------------------------------------------------
module seg_ev_eval (
   input  logic                                 clock,
   input  seg_ev_pkg::meta_type                 meta,
   input  logic [seg_ev_pkg::TIME_W-1:0]        now,
   input  logic [seg_ev_pkg::TIME_W:0]          now_margin,
   input  logic [seg_ev_pkg::TIME_W-1:0]        mature,
   input  logic [seg_ev_pkg::MODE_W-1:0]        mode,
   output seg_ev_pkg::eval_type                 result
);
   import seg_ev_pkg::*;

   logic             flags_ok_ff;
   logic [TIME_W:0]  diff_ff;
   logic [TIME_W:0]  expiry_ff;
   logic [KEY_W-1:0] key_ff;
   logic [TIME_W:0]  expiry_in;
   logic [KEY_W-1:0] key_in;
   eval_type         result_ff;
   eval_type         result_in;

   always_comb begin
      expiry_in = {1'b0, meta.created} + {2'b0, meta.ttl};
      unique case (mode)
         MODE_FIFO: begin
            key_in = (meta.created > meta.merged) ? {1'b0, meta.created} : {1'b0, meta.merged};
         end
         MODE_EXPIRY: begin
            key_in = expiry_in;
         end
         MODE_RANDOM, MODE_LIVE: begin
            key_in = {1'b0, meta.live};
         end
         default: begin
            key_in = {1'b0, meta.live};
         end
      endcase
   end

   always_comb begin
      result_in.qualified = flags_ok_ff && !diff_ff[TIME_W] &&
                            (diff_ff[TIME_W-1:0] >= mature) && (expiry_ff > now_margin);
      result_in.key = key_ff;
   end

   always_ff @(posedge clock) begin
      flags_ok_ff <= (meta.flags == FLAGS_QUALIFY);
      diff_ff     <= {1'b0, now} - {1'b0, meta.created};
      expiry_ff   <= expiry_in;
      key_ff      <= key_in;
      result_ff   <= result_in;
   end

   assign result = result_ff;

endmodule
